>>> rtl/core/dmwa_pkg.sv
package dmwa_pkg;

   // geometry of the directory window and its page tables
   localparam int DIR_SLOTS         = 64;
   localparam int ENTRIES_PER_TABLE = 1024;
   localparam int IDX_W             = $clog2(ENTRIES_PER_TABLE);
   localparam int SLOT_W            = (DIR_SLOTS > 1) ? $clog2(DIR_SLOTS) : 1;
   localparam int SCNT_W            = $clog2(DIR_SLOTS + 1);
   localparam int PG_ADDR_W         = SLOT_W + IDX_W;
   localparam int NPG_W             = 18;
   localparam int R_W               = ((PG_ADDR_W > NPG_W) ? PG_ADDR_W : NPG_W) + 1;
   localparam int RUN_W             = IDX_W + 1;
   localparam int VPG_W             = 21;

   // entry flag bits
   localparam logic [11:0] PTE_LARGE_FLAGS = 12'h093;
   localparam logic [11:0] PTE_TABLE_FLAGS = 12'h003;
   localparam logic [11:0] PTE_PAGE_FLAGS  = 12'h013;
   localparam int          PTE_LARGE_BIT   = 7;

   // register indexes
   localparam logic [1:0] CSR_WINDOW_BASE  = 2'd0;
   localparam logic [1:0] CSR_WINDOW_SLOTS = 2'd1;
   localparam logic [1:0] CSR_LARGE_ENABLE = 2'd2;
   localparam logic [1:0] CSR_TABLE_BASE   = 2'd3;

   localparam logic [31:0] WINDOW_BASE_RESET  = 32'hE000_0000;
   localparam logic [6:0]  WINDOW_SLOTS_RESET = 7'd62;
   localparam logic        LARGE_ENABLE_RESET = 1'b1;
   localparam logic [31:0] TABLE_BASE_RESET   = 32'h0000_0000;

   typedef enum logic [1:0] {
      RSP_OK,
      RSP_MAP_FAIL,
      RSP_OUT_WINDOW,
      RSP_NOT_MAPPED
   } rsp_status_type;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_LATCH,
      OP_DECODE,
      OP_DSCAN_LARGE_INIT,
      OP_DSCAN_FIRST_INIT,
      OP_DSCAN_STEP,
      OP_TSLOT_INIT,
      OP_TSLOT_NEXT,
      OP_TSCAN_INIT,
      OP_TSCAN_STEP,
      OP_WRITE_LARGE,
      OP_CLEAR_INIT,
      OP_CLEAR_STEP,
      OP_SET_TABLE,
      OP_WRITE_PAGE,
      OP_UNMAP_LARGE,
      OP_UNMAP_PAGE,
      OP_SET_RESULT,
      OP_PUSH
   } dp_op_type;

   typedef enum logic [3:0] {
      FSM_IDLE,
      FSM_DECODE,
      FSM_CLASSIFY,
      FSM_DSCAN,
      FSM_TSLOT,
      FSM_TSLOT_CHK,
      FSM_TREAD,
      FSM_TCHK,
      FSM_WLOOP,
      FSM_CLEAR,
      FSM_UWALK,
      FSM_UDIR,
      FSM_FINISH
   } fsm_state_type;

   typedef struct packed {
      dp_op_type      op;
      rsp_status_type code;
   } dp_cmd_type;

   typedef struct packed {
      logic is_unmap;
      logic early_fail;
      logic need_large;
      logic out_win;
      logic slot_end;
      logic slot_valid;
      logic dscan_hit;
      logic dir_large;
      logic idx_end;
      logic tscan_hit;
      logic entry_zero;
      logic w_done;
      logic w_over;
      logic w_large_ok;
      logic w_slot_valid;
      logic u_done;
      logic u_slot_valid;
      logic out_free;
   } dp_status_type;

endpackage

>>> rtl/core/device_map_window_allocator.sv
// device mapping window allocator
//
// request channel (req_*): one item is a map (req_cmd 0, req_paddr, req_length) or an
// unmap (req_cmd 1, req_vaddr, req_length). an item is taken when req_valid is high and
// req_stall is low; req_stall stays high while an item is being worked on.
// response channel (rsp_*): one item per request, rsp_status and rsp_mapped_addr, held in an
// output register until taken with rsp_valid high and rsp_stall low. a new request is
// accepted while an earlier response still waits.
// csr_*: plain register write port, write only while the block is idle.
// the item is decoded after it is taken, then the walk. a map of 4 MiB or more scans the
// directory flags slot by slot; a smaller map scans each existing page table entry by
// entry, then the directory. writing goes page by page or by 4 MiB entry, and each table
// created is cleared first. an unmap goes page by page or by 4 MiB entry. the response
// register is loaded last.
// the block works on one item at a time; the next item is taken once the sequencer is back in idle.
// reset clears the directory valid flags and the registers to their defaults; page tables
// need no clearing since a table is zeroed when its slot first gets it.
// a stalled response only delays the return to idle; no work is lost.
module device_map_window_allocator
   import dmwa_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_cmd,
   input  logic [31:0] req_paddr,
   input  logic [31:0] req_vaddr,
   input  logic [28:0] req_length,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_mapped_addr,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data
);

   // configuration registers
   logic [31:0] window_base_ff;
   logic [6:0]  window_slots_ff;
   logic        large_enable_ff;
   logic [31:0] table_base_ff;

   dp_cmd_type    cmd;
   dp_status_type status;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_base_ff  <= WINDOW_BASE_RESET;
         window_slots_ff <= WINDOW_SLOTS_RESET;
         large_enable_ff <= LARGE_ENABLE_RESET;
         table_base_ff   <= TABLE_BASE_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_WINDOW_BASE:  window_base_ff  <= csr_data;
            CSR_WINDOW_SLOTS: window_slots_ff <= csr_data[6:0];
            CSR_LARGE_ENABLE: large_enable_ff <= csr_data[0];
            CSR_TABLE_BASE:   table_base_ff   <= csr_data;
            default:          table_base_ff   <= table_base_ff;
         endcase
      end
   end

   // sequencer: decides each step of the walk
   dmwa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath: item registers, directory flags and memories, page table memory, response
   dmwa_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_cmd           (req_cmd),
      .req_paddr         (req_paddr),
      .req_vaddr         (req_vaddr),
      .req_length        (req_length),
      .window_base       (window_base_ff),
      .window_slots      (window_slots_ff),
      .large_page_enable (large_enable_ff),
      .table_base        (table_base_ff),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_mapped_addr   (rsp_mapped_addr)
   );

   // an accepted item keeps the block busy in the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request accepted while not busy afterwards");

   // a failed item never reports an address
   a_fail_zero_addr: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != RSP_OK) |-> (rsp_mapped_addr == 32'd0))
      else $error("failed response carries an address");

   // a new response only comes out of a busy block
   a_rsp_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("response appeared without an item in work");

endmodule

>>> rtl/core/dmwa_ctrl.sv
module dmwa_ctrl
   import dmwa_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   fsm_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FSM_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         FSM_IDLE: begin
            if (req_valid) state_in = FSM_DECODE;
         end
         FSM_DECODE: state_in = FSM_CLASSIFY;
         FSM_CLASSIFY: begin
            if (status.is_unmap) begin
               state_in = status.out_win ? FSM_FINISH : FSM_UWALK;
            end else if (status.early_fail) begin
               state_in = FSM_FINISH;
            end else if (status.need_large) begin
               state_in = FSM_DSCAN;
            end else begin
               state_in = FSM_TSLOT;
            end
         end
         FSM_DSCAN: begin
            if (status.slot_end) state_in = FSM_FINISH;
            else if (status.dscan_hit) state_in = FSM_WLOOP;
         end
         FSM_TSLOT: begin
            if (status.slot_end) state_in = FSM_DSCAN;
            else if (status.slot_valid) state_in = FSM_TSLOT_CHK;
         end
         FSM_TSLOT_CHK: begin
            state_in = status.dir_large ? FSM_TSLOT : FSM_TREAD;
         end
         FSM_TREAD: begin
            state_in = status.idx_end ? FSM_TSLOT : FSM_TCHK;
         end
         FSM_TCHK: begin
            state_in = status.tscan_hit ? FSM_WLOOP : FSM_TREAD;
         end
         FSM_WLOOP: begin
            if (status.w_done || status.w_over) state_in = FSM_FINISH;
            else if (!status.w_large_ok && !status.w_slot_valid) state_in = FSM_CLEAR;
         end
         FSM_CLEAR: begin
            if (status.idx_end) state_in = FSM_WLOOP;
         end
         FSM_UWALK: begin
            if (status.u_done || !status.u_slot_valid) state_in = FSM_FINISH;
            else state_in = FSM_UDIR;
         end
         FSM_UDIR: begin
            if (!status.dir_large && status.entry_zero) state_in = FSM_FINISH;
            else state_in = FSM_UWALK;
         end
         FSM_FINISH: begin
            if (status.out_free) state_in = FSM_IDLE;
         end
         default: state_in = FSM_IDLE;
      endcase
   end

   // commands
   always_comb begin
      cmd.op    = OP_NONE;
      cmd.code  = RSP_OK;
      req_stall = (state_ff != FSM_IDLE);
      case (state_ff)
         FSM_IDLE: begin
            if (req_valid) cmd.op = OP_LATCH;
         end
         FSM_DECODE: cmd.op = OP_DECODE;
         FSM_CLASSIFY: begin
            if (status.is_unmap) begin
               if (status.out_win) begin
                  cmd.op   = OP_SET_RESULT;
                  cmd.code = RSP_OUT_WINDOW;
               end
            end else if (status.early_fail) begin
               cmd.op   = OP_SET_RESULT;
               cmd.code = RSP_MAP_FAIL;
            end else if (status.need_large) begin
               cmd.op = OP_DSCAN_LARGE_INIT;
            end else begin
               cmd.op = OP_TSLOT_INIT;
            end
         end
         FSM_DSCAN: begin
            if (status.slot_end) begin
               cmd.op   = OP_SET_RESULT;
               cmd.code = RSP_MAP_FAIL;
            end else begin
               cmd.op = OP_DSCAN_STEP;
            end
         end
         FSM_TSLOT: begin
            if (status.slot_end) cmd.op = OP_DSCAN_FIRST_INIT;
            else if (!status.slot_valid) cmd.op = OP_TSLOT_NEXT;
         end
         FSM_TSLOT_CHK: begin
            cmd.op = status.dir_large ? OP_TSLOT_NEXT : OP_TSCAN_INIT;
         end
         FSM_TREAD: begin
            if (status.idx_end) cmd.op = OP_TSLOT_NEXT;
         end
         FSM_TCHK: cmd.op = OP_TSCAN_STEP;
         FSM_WLOOP: begin
            if (status.w_done || status.w_over) begin
               cmd.op   = OP_SET_RESULT;
               cmd.code = RSP_OK;
            end else if (status.w_large_ok) begin
               cmd.op = OP_WRITE_LARGE;
            end else if (!status.w_slot_valid) begin
               cmd.op = OP_CLEAR_INIT;
            end else begin
               cmd.op = OP_WRITE_PAGE;
            end
         end
         FSM_CLEAR: begin
            cmd.op = status.idx_end ? OP_SET_TABLE : OP_CLEAR_STEP;
         end
         FSM_UWALK: begin
            if (status.u_done) begin
               cmd.op   = OP_SET_RESULT;
               cmd.code = RSP_OK;
            end else if (!status.u_slot_valid) begin
               cmd.op   = OP_SET_RESULT;
               cmd.code = RSP_NOT_MAPPED;
            end
         end
         FSM_UDIR: begin
            if (status.dir_large) begin
               cmd.op = OP_UNMAP_LARGE;
            end else if (status.entry_zero) begin
               cmd.op   = OP_SET_RESULT;
               cmd.code = RSP_NOT_MAPPED;
            end else begin
               cmd.op = OP_UNMAP_PAGE;
            end
         end
         FSM_FINISH: begin
            if (status.out_free) cmd.op = OP_PUSH;
         end
         default: cmd.op = OP_NONE;
      endcase
   end

endmodule

>>> rtl/core/dmwa_datapath.sv
module dmwa_datapath
   import dmwa_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  dp_cmd_type    cmd,
   output dp_status_type status,
   input  logic          req_cmd,
   input  logic [31:0]   req_paddr,
   input  logic [31:0]   req_vaddr,
   input  logic [28:0]   req_length,
   input  logic [31:0]   window_base,
   input  logic [6:0]    window_slots,
   input  logic          large_page_enable,
   input  logic [31:0]   table_base,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output logic [1:0]    rsp_status,
   output logic [31:0]   rsp_mapped_addr
);

   // latched item
   logic                 unmap_ff;
   logic [31:0]          addr_ff;
   logic [28:0]          len_ff;
   // decoded
   logic [NPG_W-1:0]     npages_ff;
   logic [SCNT_W-1:0]    slots_ff;
   logic [9:0]           wb_ff;
   // scan and walk
   logic [SCNT_W-1:0]    slot_ff;
   logic [RUN_W-1:0]     idx_ff;
   logic [RUN_W-1:0]     run_ff;
   logic [RUN_W-1:0]     need_ff;
   logic [PG_ADDR_W-1:0] rel_ff;
   logic [NPG_W-1:0]     wofs_ff;
   logic [VPG_W-1:0]     va_ff;
   // directory flags, cleared at reset
   logic [DIR_SLOTS-1:0] valid_ff;
   // result
   rsp_status_type       res_status_ff;
   logic [31:0]          res_addr_ff;
   logic                 rsp_valid_ff;
   rsp_status_type       rsp_status_ff;
   logic [31:0]          rsp_addr_ff;

   // memories
   logic [31:0] page_mem [DIR_SLOTS*ENTRIES_PER_TABLE];
   logic [31:0] dir_mem  [DIR_SLOTS];
   logic [31:0] page_rdata_ff;
   logic [31:0] dir_rdata_ff;

   logic [19:0]          pg;
   logic [29:0]          size_sum;
   logic [10:0]          room;
   logic [10:0]          slot_lim;
   logic [VPG_W-1:0]     basep;
   logic [VPG_W-1:0]     endp;
   logic [VPG_W-1:0]     vae;
   logic [VPG_W-1:0]     udiff;
   logic [SLOT_W-1:0]    uslot;
   logic [SLOT_W-1:0]    sslot;
   logic [R_W-1:0]       r;
   logic [SLOT_W-1:0]    wslot;
   logic [19:0]          p;
   logic [NPG_W-1:0]     rem;
   logic [RUN_W:0]       run_inc;
   logic [SCNT_W-1:0]    start_slot;
   logic                 pg_we;
   logic [PG_ADDR_W-1:0] pg_waddr;
   logic [31:0]          pg_wdata;
   logic [PG_ADDR_W-1:0] pg_raddr;
   logic                 dir_we;
   logic [31:0]          dir_wdata;
   logic [SLOT_W-1:0]    dir_raddr;

   assign pg       = addr_ff[31:12];
   assign size_sum = {1'b0, len_ff} + {18'd0, addr_ff[11:0]} + 30'h0000_0FFF;
   assign room     = 11'd1024 - {1'b0, window_base[31:22]};

   always_comb begin
      slot_lim = {4'd0, window_slots};
      if (slot_lim > 11'(DIR_SLOTS)) slot_lim = 11'(DIR_SLOTS);
      if (slot_lim > room) slot_lim = room;
   end

   // window bounds in pages
   assign basep = {1'b0, wb_ff, 10'd0};
   assign endp  = {({1'b0, wb_ff} + 11'(slots_ff)), 10'd0};
   assign vae   = {1'b0, pg} + VPG_W'(npages_ff);
   assign udiff = va_ff - basep;
   assign uslot = udiff[PG_ADDR_W-1:IDX_W];
   assign sslot = slot_ff[SLOT_W-1:0];

   // map write walk
   assign r          = R_W'(rel_ff) + R_W'(wofs_ff);
   assign wslot      = r[PG_ADDR_W-1:IDX_W];
   assign p          = pg + 20'(wofs_ff);
   assign rem        = npages_ff - wofs_ff;
   assign run_inc    = {1'b0, run_ff} + (RUN_W+1)'(1);
   assign start_slot = slot_ff - SCNT_W'(run_ff);

   assign dir_raddr = unmap_ff ? uslot : sslot;
   assign pg_raddr  = unmap_ff ? udiff[PG_ADDR_W-1:0] : {sslot, idx_ff[IDX_W-1:0]};

   always_comb begin
      status.is_unmap     = unmap_ff;
      status.early_fail   = (len_ff == 29'd0) || (pg == 20'd0);
      status.need_large   = (npages_ff >= NPG_W'(ENTRIES_PER_TABLE));
      status.out_win      = ({1'b0, pg} < basep) || (vae > endp);
      status.slot_end     = (slot_ff >= slots_ff);
      status.slot_valid   = valid_ff[sslot];
      status.dscan_hit    = !valid_ff[sslot] && (run_inc >= {1'b0, need_ff});
      status.dir_large    = dir_rdata_ff[PTE_LARGE_BIT];
      status.idx_end      = idx_ff[IDX_W];
      status.entry_zero   = (page_rdata_ff == 32'd0);
      status.tscan_hit    = (page_rdata_ff == 32'd0) && (run_inc >= {1'b0, need_ff});
      status.w_done       = (wofs_ff >= npages_ff);
      status.w_over       = ((r >> IDX_W) >= R_W'(DIR_SLOTS));
      status.w_large_ok   = large_page_enable && (p[IDX_W-1:0] == '0) &&
                            (r[IDX_W-1:0] == '0) && (rem >= NPG_W'(ENTRIES_PER_TABLE));
      status.w_slot_valid = valid_ff[wslot];
      status.u_done       = (va_ff >= vae);
      status.u_slot_valid = valid_ff[uslot];
      status.out_free     = !rsp_valid_ff || !rsp_stall;
   end

   // memory write ports
   always_comb begin
      pg_we     = 1'b0;
      pg_waddr  = {sslot, idx_ff[IDX_W-1:0]};
      pg_wdata  = 32'd0;
      dir_we    = 1'b0;
      dir_wdata = {p, PTE_LARGE_FLAGS};
      case (cmd.op)
         OP_CLEAR_STEP: begin
            pg_we    = 1'b1;
            pg_waddr = {wslot, idx_ff[IDX_W-1:0]};
         end
         OP_WRITE_PAGE: begin
            pg_we    = 1'b1;
            pg_waddr = r[PG_ADDR_W-1:0];
            pg_wdata = {p, PTE_PAGE_FLAGS};
         end
         OP_UNMAP_PAGE: begin
            pg_we    = 1'b1;
            pg_waddr = udiff[PG_ADDR_W-1:0];
         end
         OP_WRITE_LARGE: dir_we = 1'b1;
         OP_SET_TABLE: begin
            dir_we    = 1'b1;
            dir_wdata = {table_base[31:12] + 20'(wslot), PTE_TABLE_FLAGS};
         end
         default: pg_we = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (pg_we) page_mem[pg_waddr] <= pg_wdata;
      page_rdata_ff <= page_mem[pg_raddr];
   end

   always_ff @(posedge clock) begin
      if (dir_we) dir_mem[wslot] <= dir_wdata;
      dir_rdata_ff <= dir_mem[dir_raddr];
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (cmd.op)
            OP_WRITE_LARGE: valid_ff[wslot] <= 1'b1;
            OP_SET_TABLE:   valid_ff[wslot] <= 1'b1;
            OP_UNMAP_LARGE: valid_ff[uslot] <= 1'b0;
            default:        valid_ff <= valid_ff;
         endcase
         if (cmd.op == OP_PUSH) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      end
   end

   // payload and working registers
   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_LATCH: begin
            unmap_ff <= req_cmd;
            addr_ff  <= req_cmd ? req_vaddr : req_paddr;
            len_ff   <= req_length;
         end
         OP_DECODE: begin
            npages_ff <= size_sum[29:12];
            slots_ff  <= slot_lim[SCNT_W-1:0];
            wb_ff     <= window_base[31:22];
            va_ff     <= {1'b0, pg};
         end
         OP_DSCAN_LARGE_INIT: begin
            slot_ff <= '0;
            run_ff  <= '0;
            need_ff <= RUN_W'(({1'b0, npages_ff} + (NPG_W+1)'(ENTRIES_PER_TABLE - 1)) >> IDX_W);
         end
         OP_DSCAN_FIRST_INIT: begin
            slot_ff <= '0;
            run_ff  <= '0;
            need_ff <= RUN_W'(1);
         end
         OP_DSCAN_STEP: begin
            slot_ff <= slot_ff + SCNT_W'(1);
            if (!valid_ff[sslot]) begin
               run_ff <= run_inc[RUN_W-1:0];
               if (run_inc >= {1'b0, need_ff}) begin
                  rel_ff  <= {start_slot[SLOT_W-1:0], IDX_W'(0)};
                  wofs_ff <= '0;
               end
            end else begin
               run_ff <= '0;
            end
         end
         OP_TSLOT_INIT: begin
            slot_ff <= '0;
            need_ff <= npages_ff[RUN_W-1:0];
         end
         OP_TSLOT_NEXT: slot_ff <= slot_ff + SCNT_W'(1);
         OP_TSCAN_INIT: begin
            idx_ff <= '0;
            run_ff <= '0;
         end
         OP_TSCAN_STEP: begin
            idx_ff <= idx_ff + RUN_W'(1);
            if (page_rdata_ff == 32'd0) begin
               run_ff <= run_inc[RUN_W-1:0];
               if (run_inc >= {1'b0, need_ff}) begin
                  rel_ff  <= {sslot, idx_ff[IDX_W-1:0] - run_ff[IDX_W-1:0]};
                  wofs_ff <= '0;
               end
            end else begin
               run_ff <= '0;
            end
         end
         OP_WRITE_LARGE: wofs_ff <= wofs_ff + NPG_W'(ENTRIES_PER_TABLE);
         OP_CLEAR_INIT:  idx_ff  <= '0;
         OP_CLEAR_STEP:  idx_ff  <= idx_ff + RUN_W'(1);
         OP_WRITE_PAGE:  wofs_ff <= wofs_ff + NPG_W'(1);
         OP_UNMAP_LARGE: begin
            va_ff <= (va_ff + VPG_W'(ENTRIES_PER_TABLE)) & ~VPG_W'(ENTRIES_PER_TABLE - 1);
         end
         OP_UNMAP_PAGE:  va_ff <= va_ff + VPG_W'(1);
         OP_SET_RESULT: begin
            res_status_ff <= cmd.code;
            if (!unmap_ff && cmd.code == RSP_OK) begin
               res_addr_ff <= {wb_ff, 22'd0} + 32'({rel_ff, addr_ff[11:0]});
            end else begin
               res_addr_ff <= 32'd0;
            end
         end
         OP_PUSH: begin
            rsp_status_ff <= res_status_ff;
            rsp_addr_ff   <= res_addr_ff;
         end
         default: idx_ff <= idx_ff;
      endcase
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_mapped_addr = rsp_addr_ff;

endmodule
